/* rtl/cvir_pkg.sv */
// ----------------------------------------------------------------------------
// cvir_pkg: shared types and constants for the cluster vertex index remapper
// Holds capacity constants, the queue entry type and the engine state codes.
// ----------------------------------------------------------------------------
package cvir_pkg;

	localparam int unsigned LOCAL_CAP          = 384;
	localparam int unsigned IDX_W              = 9;
	localparam int unsigned ID_W               = 16;
	localparam int unsigned MAX_VERTICES_DEF   = 65536;
	localparam int unsigned MAX_TRIANGLES_DEF  = 128;
	localparam logic [IDX_W-1:0] INDEX_COUNT_RST = 9'd384;

	typedef struct packed {
		logic [ID_W-1:0] vertex_a;
		logic [ID_W-1:0] vertex_b;
		logic [ID_W-1:0] vertex_c;
		logic            last_in_cluster;
	} tri_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_CORNER,
		ST_DONE,
		ST_FLUSH
	} eng_state_t;

endpackage

/* rtl/cvir_front.sv */
// ----------------------------------------------------------------------------
// cvir_front: input side of the remapper
// Accepts triangles into a two-entry queue that feeds the remap engine.
// ----------------------------------------------------------------------------
module cvir_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cvir_pkg::tri_t  in_tri,
	output logic            q_valid,
	input  logic            q_pop,
	output cvir_pkg::tri_t  q_tri
);

	cvir_pkg::tri_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_tri    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_tri;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

/* rtl/cvir_engine.sv */
// ----------------------------------------------------------------------------
// cvir_engine: mark table lookup, local index assignment and cluster flush
// Walks one triangle's corners through a mark table with separate read and
// write ports, then clears the finished cluster's marks via the used list.
// ----------------------------------------------------------------------------
module cvir_engine #(
	parameter int unsigned MAX_VERTICES  = cvir_pkg::MAX_VERTICES_DEF,
	parameter int unsigned MAX_TRIANGLES = cvir_pkg::MAX_TRIANGLES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [cvir_pkg::IDX_W-1:0] index_count,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  cvir_pkg::tri_t             q_tri,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [cvir_pkg::IDX_W-1:0] local_a,
	output logic [cvir_pkg::IDX_W-1:0] local_b,
	output logic [cvir_pkg::IDX_W-1:0] local_c,
	output logic [2:0]                 new_mask,
	output logic [2:0]                 index_valid_mask,
	output logic [cvir_pkg::IDX_W-1:0] pad_count,
	output logic                       cluster_end,
	output logic [cvir_pkg::IDX_W-1:0] vertex_total,
	output logic                       overflow
);

	localparam int unsigned AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int unsigned TW  = $clog2(MAX_TRIANGLES + 1);
	localparam int unsigned IW  = cvir_pkg::IDX_W;
	localparam int unsigned UW  = $clog2(cvir_pkg::LOCAL_CAP);
	localparam logic [IW-1:0] CAP = IW'(cvir_pkg::LOCAL_CAP);
	localparam logic [TW-1:0] TRI_CAP = TW'(MAX_TRIANGLES);

	// mark table: valid bit and local index; used list: slot per local vertex
	logic [IW:0]   mark_mem [MAX_VERTICES];
	logic [AW-1:0] used_mem [cvir_pkg::LOCAL_CAP];

	cvir_pkg::eng_state_t state_q, state_d;

	logic [AW-1:0] slot_q [3];
	logic          last_q;
	logic [IW:0]   rd_data_q;
	logic [AW-1:0] used_rd_q;
	logic [1:0]    k_q;
	logic [IW-1:0] lvc_q;
	logic [IW-1:0] iw_q;
	logic [TW-1:0] tri_q;
	logic [IW-1:0] loc_q [3];
	logic [2:0]    nm_q;
	logic [2:0]    vm_q;
	logic          rej_q;
	logic [IW:0]   mark_seen_q [3];
	logic [AW:0]   clr_q;
	logic [IW-1:0] fl_q;
	logic          fl_rd_q;

	// result register
	logic          ov_q;
	logic [IW-1:0] o_la_q, o_lb_q, o_lc_q, o_pad_q, o_tot_q;
	logic [2:0]    o_nm_q, o_vm_q;
	logic          o_end_q, o_rej_q;

	logic [IW-1:0] limit;
	logic [1:0]    needed;
	logic          new0, new1, new2;
	logic          reject;
	logic          mk_wr;
	logic [AW-1:0] mk_addr;
	logic [IW:0]   mk_wdata;
	logic          cur_new;
	logic [IW-1:0] cur_loc;
	logic          dup_prev;
	logic [IW-1:0] dup_loc;
	logic [IW-1:0] iw_next;
	logic [IW-1:0] pad_val;

	assign limit = (index_count > CAP) ? CAP : index_count;

	// corner freshness against the table and earlier corners of this triangle;
	// the third corner's mark still sits in the read register when this is used
	always_comb begin
		new0   = !mark_seen_q[0][IW];
		new1   = !mark_seen_q[1][IW] && (slot_q[1] != slot_q[0]);
		new2   = !rd_data_q[IW] && (slot_q[2] != slot_q[0]) && (slot_q[2] != slot_q[1]);
		needed = {1'b0, new0} + {1'b0, new1} + {1'b0, new2};
		reject = (tri_q >= TRI_CAP) || ({1'b0, lvc_q} + {8'd0, needed} > {1'b0, CAP});
	end

	// corner k: fresh this triangle, or repeat of an earlier corner
	always_comb begin
		dup_prev = 1'b0;
		dup_loc  = '0;
		if (k_q == 2'd1 && slot_q[1] == slot_q[0]) begin
			dup_prev = 1'b1;
			dup_loc  = loc_q[0];
		end else if (k_q == 2'd2 && slot_q[2] == slot_q[0]) begin
			dup_prev = 1'b1;
			dup_loc  = loc_q[0];
		end else if (k_q == 2'd2 && slot_q[2] == slot_q[1]) begin
			dup_prev = 1'b1;
			dup_loc  = loc_q[1];
		end
		cur_new = !dup_prev && !mark_seen_q[k_q][IW];
		cur_loc = dup_prev ? dup_loc : (cur_new ? lvc_q : mark_seen_q[k_q][IW-1:0]);
		iw_next = iw_q + ((iw_q < limit) ? IW'(1) : IW'(0));
		pad_val = (limit > iw_q) ? (limit - iw_q) : '0;
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		mk_wr    = 1'b0;
		mk_addr  = slot_q[k_q];
		mk_wdata = {1'b1, lvc_q};
		case (state_q)
			cvir_pkg::ST_CLEAR: begin
				mk_wr    = 1'b1;
				mk_addr  = clr_q[AW-1:0];
				mk_wdata = '0;
				if (clr_q == (AW+1)'(MAX_VERTICES - 1)) state_d = cvir_pkg::ST_IDLE;
			end
			cvir_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = cvir_pkg::ST_LOOK;
				end
			end
			cvir_pkg::ST_LOOK: begin
				if (k_q == 2'd2) state_d = reject ? cvir_pkg::ST_DONE : cvir_pkg::ST_CORNER;
			end
			cvir_pkg::ST_CORNER: begin
				mk_wr = cur_new;
				if (k_q == 2'd2) state_d = cvir_pkg::ST_DONE;
			end
			cvir_pkg::ST_DONE: begin
				if (!ov_q) begin
					state_d = (last_q && lvc_q != '0) ? cvir_pkg::ST_FLUSH : cvir_pkg::ST_IDLE;
				end
			end
			cvir_pkg::ST_FLUSH: begin
				mk_wr    = fl_rd_q;
				mk_addr  = used_rd_q;
				mk_wdata = '0;
				if (fl_rd_q && fl_q == lvc_q) state_d = cvir_pkg::ST_IDLE;
			end
			default: state_d = cvir_pkg::ST_IDLE;
		endcase
	end

	// table lookups issue one per cycle, one corner ahead, with registered read
	logic [AW-1:0] rd_addr;
	always_comb begin
		rd_addr = slot_q[k_q];
		if (state_q == cvir_pkg::ST_IDLE) rd_addr = AW'(q_tri.vertex_a);
		if (state_q == cvir_pkg::ST_LOOK) rd_addr = (k_q == 2'd0) ? slot_q[1] : slot_q[2];
	end

	always_ff @(posedge clk) begin
		if (mk_wr) mark_mem[mk_addr] <= mk_wdata;
		rd_data_q <= mark_mem[rd_addr];
		if (state_q == cvir_pkg::ST_CORNER && cur_new) used_mem[lvc_q[UW-1:0]] <= slot_q[k_q];
		used_rd_q <= used_mem[fl_q[UW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cvir_pkg::ST_CLEAR;
			clr_q   <= '0;
			k_q     <= '0;
			lvc_q   <= '0;
			iw_q    <= '0;
			tri_q   <= '0;
			nm_q    <= '0;
			vm_q    <= '0;
			rej_q   <= 1'b0;
			last_q  <= 1'b0;
			ov_q    <= 1'b0;
			fl_q    <= '0;
			fl_rd_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				slot_q[i]      <= '0;
				loc_q[i]       <= '0;
				mark_seen_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				cvir_pkg::ST_CLEAR: clr_q <= clr_q + (AW+1)'(1);
				cvir_pkg::ST_IDLE: begin
					k_q <= '0;
					if (q_valid) begin
						slot_q[0] <= AW'(q_tri.vertex_a);
						slot_q[1] <= AW'(q_tri.vertex_b);
						slot_q[2] <= AW'(q_tri.vertex_c);
						last_q    <= q_tri.last_in_cluster;
						nm_q      <= '0;
						vm_q      <= '0;
						loc_q[0]  <= '0;
						loc_q[1]  <= '0;
						loc_q[2]  <= '0;
					end
				end
				cvir_pkg::ST_LOOK: begin
					// data for corner k arrives in the cycle after its address
					mark_seen_q[k_q] <= rd_data_q;
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				cvir_pkg::ST_CORNER: begin
					loc_q[k_q] <= cur_loc;
					if (cur_new) begin
						nm_q[k_q] <= 1'b1;
						lvc_q     <= lvc_q + IW'(1);
					end
					if (iw_q < limit) vm_q[k_q] <= 1'b1;
					iw_q <= iw_next;
					if (k_q == 2'd2) tri_q <= tri_q + TW'(1);
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				cvir_pkg::ST_DONE: begin
					if (!ov_q) begin
						ov_q    <= 1'b1;
						o_la_q  <= loc_q[0];
						o_lb_q  <= loc_q[1];
						o_lc_q  <= loc_q[2];
						o_nm_q  <= nm_q;
						o_vm_q  <= vm_q;
						o_end_q <= last_q;
						o_tot_q <= lvc_q;
						o_rej_q <= rej_q;
						o_pad_q <= last_q ? pad_val : '0;
						fl_q    <= '0;
						fl_rd_q <= 1'b0;
						if (last_q) begin
							iw_q  <= '0;
							tri_q <= '0;
							if (lvc_q == '0) lvc_q <= '0;
						end
					end
				end
				cvir_pkg::ST_FLUSH: begin
					// used list read is registered, so the address runs ahead of the mark write
					fl_rd_q <= 1'b1;
					fl_q    <= fl_q + IW'(1);
					if (fl_rd_q && fl_q == lvc_q) lvc_q <= '0;
				end
				default: ;
			endcase
			if (state_q == cvir_pkg::ST_LOOK && k_q == 2'd2) rej_q <= reject;
			if (state_q == cvir_pkg::ST_IDLE) rej_q <= 1'b0;
		end
	end

	assign out_valid        = ov_q;
	assign local_a          = o_la_q;
	assign local_b          = o_lb_q;
	assign local_c          = o_lc_q;
	assign new_mask         = o_nm_q;
	assign index_valid_mask = o_vm_q;
	assign pad_count        = o_pad_q;
	assign cluster_end      = o_end_q;
	assign vertex_total     = o_tot_q;
	assign overflow         = o_rej_q;

endmodule

/* rtl/cluster_vertex_index_remap_unit.sv */
// Once a triangle sits in the input queue, the remap engine pops it and sends
// the first corner's address to the mark table, looks up the three corners in
// turn, then commits new marks corner by corner, and loads the output register.
// A rejected triangle skips the commits. The engine loads a result only when
// the output register is free, so a stalled receiver holds the engine in its
// load state. A triangle that closes a cluster then clears its marks via the
// used list. After reset the mark table is cleared one entry per cycle before
// the first triangle is taken; the two-entry input queue still accepts
// meanwhile, and index_count writes are taken at any time.
// ----------------------------------------------------------------------------
// cluster_vertex_index_remap_unit: cluster-local vertex index remapper
// Front queue accepts triangles; engine assigns local indices per cluster.
// ----------------------------------------------------------------------------
module cluster_vertex_index_remap_unit #(
	parameter int unsigned MAX_VERTICES  = cvir_pkg::MAX_VERTICES_DEF,
	parameter int unsigned MAX_TRIANGLES = cvir_pkg::MAX_TRIANGLES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cvir_pkg::IDX_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [cvir_pkg::ID_W-1:0]  vertex_a,
	input  logic [cvir_pkg::ID_W-1:0]  vertex_b,
	input  logic [cvir_pkg::ID_W-1:0]  vertex_c,
	input  logic                       last_in_cluster,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [cvir_pkg::IDX_W-1:0] local_a,
	output logic [cvir_pkg::IDX_W-1:0] local_b,
	output logic [cvir_pkg::IDX_W-1:0] local_c,
	output logic [2:0]                 new_mask,
	output logic [2:0]                 index_valid_mask,
	output logic [cvir_pkg::IDX_W-1:0] pad_count,
	output logic                       cluster_end,
	output logic [cvir_pkg::IDX_W-1:0] vertex_total,
	output logic                       overflow
);

	logic [cvir_pkg::IDX_W-1:0] index_count_q;
	cvir_pkg::tri_t             in_tri, q_tri;
	logic                       q_valid, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_count_q <= cvir_pkg::INDEX_COUNT_RST;
		end else if (cfg_valid) begin
			index_count_q <= cfg_data;
		end
	end

	assign in_tri = '{vertex_a: vertex_a, vertex_b: vertex_b, vertex_c: vertex_c,
		last_in_cluster: last_in_cluster};

	cvir_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_tri   (in_tri),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_tri    (q_tri)
	);

	cvir_engine #(
		.MAX_VERTICES  (MAX_VERTICES),
		.MAX_TRIANGLES (MAX_TRIANGLES)
	) u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.index_count      (index_count_q),
		.q_valid          (q_valid),
		.q_pop            (q_pop),
		.q_tri            (q_tri),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.local_a          (local_a),
		.local_b          (local_b),
		.local_c          (local_c),
		.new_mask         (new_mask),
		.index_valid_mask (index_valid_mask),
		.pad_count        (pad_count),
		.cluster_end      (cluster_end),
		.vertex_total     (vertex_total),
		.overflow         (overflow)
	);

endmodule
